>>> hdl/tofdi_pkg.sv
// ----------------------------------------------------------------------------
// tofdi_pkg
// Shared types and constants for the time-of-flight delay index block.
// ----------------------------------------------------------------------------
package tofdi_pkg;

  localparam int unsigned COORD_W   = 24;
  localparam int unsigned DIFF_W    = COORD_W + 1;
  localparam int unsigned SQ_W      = 2 * DIFF_W;
  localparam int unsigned D2_W      = 50;
  localparam int unsigned OFFS_W    = 33;
  localparam int unsigned X_W       = 62;   // squared distance scaled by 4096
  localparam int unsigned ROOT_W    = 31;
  localparam int unsigned SQRT_STAGES = ROOT_W;
  localparam int unsigned DIV1_W    = 41;   // root * 1000
  localparam int unsigned DIV2_W    = 43;   // magnitude of the numerator
  localparam int unsigned SPEED_W   = 15;
  localparam int unsigned PERIOD_W  = 20;
  localparam int unsigned DELAY_W   = 32;
  localparam int unsigned NSAMP_W   = 17;
  localparam int unsigned DIVSR_W   = PERIOD_W + 6;
  localparam int unsigned Q_W       = 45;
  localparam int unsigned OVER_W    = 32;
  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned DATA_W    = 32;
  localparam logic [9:0]  NS_PER_US = 10'd1000;

  // start to strobe, in cycles
  localparam int unsigned LATENCY   = 8 + SQRT_STAGES + DIV1_W + DIV2_W;

  localparam logic [1:0] REG_SOUND_SPEED   = 2'd0;
  localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd1;
  localparam logic [1:0] REG_START_DELAY   = 2'd2;
  localparam logic [1:0] REG_NUM_SAMPLES   = 2'd3;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dz;
    logic signed [OFFS_W-1:0] offs;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic [SPEED_W-1:0]  sound_speed;
    logic [PERIOD_W-1:0] sample_period;
    logic [DELAY_W-1:0]  start_delay;
    logic [NSAMP_W-1:0]  num_samples;
  } cfg_t;

endpackage

>>> hdl/time_of_flight_delay_index.sv
// ----------------------------------------------------------------------------
// time_of_flight_delay_index
// Per element delay to a rounded sample index, with window check.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------------------
//  input   | start && !busy        | obs_x/y/z, elem_x/y/z, focus/steer offset
//  result  | out_strobe, one cycle | sample_index, out_of_range, overshoot
//  config  | psel&penable&pwrite   | sound_speed, sample_period, start_delay,
//          |                       | num_samples at 0x0, 0x4, 0x8, 0xC
//
//  One word per cycle while busy is low; each word passes through the 31 root
//  stages and the 41 and 43 stage dividers, one quotient bit per divider
//  stage.
//  rst_n is synchronous; it clears control state and loads the config
//  registers with their reset values.
//  The result side cannot stall and the back end never holds off, so the
//  queue drains every cycle and busy stays low in practice.
// ----------------------------------------------------------------------------
module time_of_flight_delay_index #(
  parameter int unsigned INDEX_BITS = 16,
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [23:0]                   in_obs_x,
  input  logic signed [23:0]                   in_obs_y,
  input  logic signed [23:0]                   in_obs_z,
  input  logic signed [23:0]                   in_elem_x,
  input  logic signed [23:0]                   in_elem_y,
  input  logic signed [23:0]                   in_elem_z,
  input  logic signed [31:0]                   in_focus_offset,
  input  logic signed [31:0]                   in_steer_offset,
  output logic                                 out_strobe,
  output logic [INDEX_BITS-1:0]                out_sample_index,
  output logic                                 out_out_of_range,
  output logic signed [31:0]                   out_overshoot,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [tofdi_pkg::ADDR_W-1:0]         paddr,
  input  logic [tofdi_pkg::DATA_W-1:0]         pwdata,
  output logic [tofdi_pkg::DATA_W-1:0]         prdata,
  output logic                                 pready
);

  // config registers
  tofdi_pkg::cfg_t cfg_r;
  logic            wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sound_speed   <= 15'd1500;
      cfg_r.sample_period <= 20'd100;
      cfg_r.start_delay   <= 32'd0;
      cfg_r.num_samples   <= 17'd1024;
    end else if (wr) begin
      case (paddr[3:2])
        tofdi_pkg::REG_SOUND_SPEED:   cfg_r.sound_speed   <= pwdata[14:0];
        tofdi_pkg::REG_SAMPLE_PERIOD: cfg_r.sample_period <= pwdata[19:0];
        tofdi_pkg::REG_START_DELAY:   cfg_r.start_delay   <= pwdata;
        tofdi_pkg::REG_NUM_SAMPLES:   cfg_r.num_samples   <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      tofdi_pkg::REG_SOUND_SPEED:   prdata = {17'b0, cfg_r.sound_speed};
      tofdi_pkg::REG_SAMPLE_PERIOD: prdata = {12'b0, cfg_r.sample_period};
      tofdi_pkg::REG_START_DELAY:   prdata = cfg_r.start_delay;
      tofdi_pkg::REG_NUM_SAMPLES:   prdata = {15'b0, cfg_r.num_samples};
      default:                      prdata = '0;
    endcase
  end

  // front -> queue -> back
  tofdi_pkg::fifo_stat_t fstat;
  tofdi_pkg::entry_t     f_entry, b_entry;
  logic                  push, pop;

  tofdi_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_obs_x        (in_obs_x),
    .in_obs_y        (in_obs_y),
    .in_obs_z        (in_obs_z),
    .in_elem_x       (in_elem_x),
    .in_elem_y       (in_elem_y),
    .in_elem_z       (in_elem_z),
    .in_focus_offset (in_focus_offset),
    .in_steer_offset (in_steer_offset),
    .fstat           (fstat),
    .push            (push),
    .entry           (f_entry)
  );

  tofdi_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (f_entry),
    .pop   (pop),
    .rdata (b_entry),
    .fstat (fstat)
  );

  tofdi_back #(.INDEX_BITS(INDEX_BITS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .fstat            (fstat),
    .entry            (b_entry),
    .pop              (pop),
    .out_strobe       (out_strobe),
    .out_sample_index (out_sample_index),
    .out_out_of_range (out_out_of_range),
    .out_overshoot    (out_overshoot)
  );

  // checks
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(tofdi_pkg::LATENCY) out_strobe)
    else $error("word taken but no result after pipeline latency");

  a_no_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("queue backed up although back end never stalls");

  a_oor_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_out_of_range) |-> (out_sample_index == '0))
    else $error("index not cleared when out of window");

  a_inr_over: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_out_of_range) |-> (out_overshoot == '0))
    else $error("overshoot set for an in-window index");

endmodule

>>> hdl/tofdi_front.sv
// ----------------------------------------------------------------------------
// tofdi_front
// Takes a word, forms coordinate differences and the summed element delays.
// ----------------------------------------------------------------------------
module tofdi_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [tofdi_pkg::COORD_W-1:0]  in_obs_x,
  input  logic signed [tofdi_pkg::COORD_W-1:0]  in_obs_y,
  input  logic signed [tofdi_pkg::COORD_W-1:0]  in_obs_z,
  input  logic signed [tofdi_pkg::COORD_W-1:0]  in_elem_x,
  input  logic signed [tofdi_pkg::COORD_W-1:0]  in_elem_y,
  input  logic signed [tofdi_pkg::COORD_W-1:0]  in_elem_z,
  input  logic signed [31:0]                    in_focus_offset,
  input  logic signed [31:0]                    in_steer_offset,
  input  tofdi_pkg::fifo_stat_t                 fstat,
  output logic                                  push,
  output tofdi_pkg::entry_t                     entry
);

  logic              vld_r, vld_nxt;
  tofdi_pkg::entry_t ent_r;
  logic              acc;

  assign busy  = vld_r && fstat.full;
  assign acc   = start && !busy;
  assign push  = vld_r && !fstat.full;
  assign entry = ent_r;

  always_comb begin
    vld_nxt = vld_r;
    if (acc) begin
      vld_nxt = 1'b1;
    end else if (push) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (acc) begin
      ent_r.dx   <= {in_obs_x[23], in_obs_x} - {in_elem_x[23], in_elem_x};
      ent_r.dy   <= {in_obs_y[23], in_obs_y} - {in_elem_y[23], in_elem_y};
      ent_r.dz   <= {in_obs_z[23], in_obs_z} - {in_elem_z[23], in_elem_z};
      ent_r.offs <= {in_focus_offset[31], in_focus_offset}
                  + {in_steer_offset[31], in_steer_offset};
    end
  end

endmodule

>>> hdl/tofdi_fifo.sv
// ----------------------------------------------------------------------------
// tofdi_fifo
// Short queue between front and back.
// ----------------------------------------------------------------------------
module tofdi_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  tofdi_pkg::entry_t     wdata,
  input  logic                  pop,
  output tofdi_pkg::entry_t     rdata,
  output tofdi_pkg::fifo_stat_t fstat
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULLC = CW'(DEPTH);

  tofdi_pkg::entry_t mem_r [DEPTH];
  logic [PW-1:0]     wp_r, rp_r;
  logic [CW-1:0]     cnt_r;
  logic              do_push, do_pop;

  assign fstat.full  = (cnt_r == FULLC);
  assign fstat.empty = (cnt_r == '0);
  assign do_push     = push && !fstat.full;
  assign do_pop      = pop && !fstat.empty;
  assign rdata       = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == LAST) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == LAST) ? '0 : rp_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
    if (do_push) mem_r[wp_r] <= wdata;
  end

endmodule

>>> hdl/tofdi_udiv.sv
// ----------------------------------------------------------------------------
// tofdi_udiv
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tofdi_udiv #(
  parameter int unsigned DW = 41,
  parameter int unsigned VW = 15,
  parameter int unsigned PW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld_i,
  input  logic [DW-1:0] dvd_i,
  input  logic [VW-1:0] div_i,   // nonzero, static while busy
  input  logic [PW-1:0] pay_i,
  output logic          vld_o,
  output logic [DW-1:0] quo_o,
  output logic [VW-1:0] rem_o,
  output logic [PW-1:0] pay_o
);

  logic          vld_r  [DW];
  logic [VW-1:0] rem_r  [DW];
  logic [DW-1:0] work_r [DW];
  logic [PW-1:0] pay_r  [DW];

  for (genvar k = 0; k < DW; k++) begin : g_stg
    logic          vin;
    logic [VW-1:0] rin;
    logic [DW-1:0] win;
    logic [PW-1:0] pin;
    logic [VW:0]   sh, diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign vin = vld_i;
      assign rin = '0;
      assign win = dvd_i;
      assign pin = pay_i;
    end else begin : g_next
      assign vin = vld_r[k-1];
      assign rin = rem_r[k-1];
      assign win = work_r[k-1];
      assign pin = pay_r[k-1];
    end

    assign sh   = {rin, win[DW-1]};
    assign ge   = sh >= {1'b0, div_i};
    assign diff = sh - {1'b0, div_i};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vin;
      end
      rem_r[k]  <= ge ? diff[VW-1:0] : sh[VW-1:0];
      work_r[k] <= {win[DW-2:0], ge};
      pay_r[k]  <= pin;
    end
  end

  assign vld_o = vld_r[DW-1];
  assign quo_o = work_r[DW-1];
  assign rem_o = rem_r[DW-1];
  assign pay_o = pay_r[DW-1];

endmodule

>>> hdl/tofdi_back.sv
// ----------------------------------------------------------------------------
// tofdi_back
// Distance, flight time, sample division, rounding and window check.
// ----------------------------------------------------------------------------
module tofdi_back #(
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  tofdi_pkg::cfg_t                        cfg,
  input  tofdi_pkg::fifo_stat_t                  fstat,
  input  tofdi_pkg::entry_t                      entry,
  output logic                                   pop,
  output logic                                   out_strobe,
  output logic [INDEX_BITS-1:0]                  out_sample_index,
  output logic                                   out_out_of_range,
  output logic signed [tofdi_pkg::OVER_W-1:0]    out_overshoot
);

  localparam int unsigned OW  = tofdi_pkg::OFFS_W;
  localparam int unsigned RW  = tofdi_pkg::ROOT_W;
  localparam int unsigned XW  = tofdi_pkg::X_W;
  localparam int unsigned REMW = RW + 2;
  localparam int unsigned D1  = tofdi_pkg::DIV1_W;
  localparam int unsigned D2  = tofdi_pkg::DIV2_W;
  localparam int unsigned VW2 = tofdi_pkg::DIVSR_W;
  localparam int unsigned QW  = tofdi_pkg::Q_W;
  localparam logic [33:0] CAP = 34'(1) << INDEX_BITS;

  // effective divisors: zero reads as one
  logic [tofdi_pkg::SPEED_W-1:0]  c_eff;
  logic [tofdi_pkg::PERIOD_W-1:0] p_eff;
  logic [VW2-1:0]                 dsr;
  logic [33:0]                    win;

  assign c_eff = (cfg.sound_speed == '0) ? 15'd1 : cfg.sound_speed;
  assign p_eff = (cfg.sample_period == '0) ? 20'd1 : cfg.sample_period;
  assign dsr   = {p_eff, 6'b0};
  assign win   = ({17'b0, cfg.num_samples} > CAP) ? CAP : {17'b0, cfg.num_samples};

  assign pop = !fstat.empty;

  // squares, then sum
  logic                         b1_vld_r, b2_vld_r;
  logic signed [tofdi_pkg::SQ_W-1:0] sx_r, sy_r, sz_r;
  logic [OW-1:0]                b1_off_r, b2_off_r;
  logic [tofdi_pkg::D2_W-1:0]   d2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r <= 1'b0;
      b2_vld_r <= 1'b0;
    end else begin
      b1_vld_r <= pop;
      b2_vld_r <= b1_vld_r;
    end
    sx_r     <= tofdi_pkg::SQ_W'(entry.dx) * tofdi_pkg::SQ_W'(entry.dx);
    sy_r     <= tofdi_pkg::SQ_W'(entry.dy) * tofdi_pkg::SQ_W'(entry.dy);
    sz_r     <= tofdi_pkg::SQ_W'(entry.dz) * tofdi_pkg::SQ_W'(entry.dz);
    b1_off_r <= entry.offs;
    d2_r     <= sx_r[49:0] + sy_r[49:0] + sz_r[49:0];
    b2_off_r <= b1_off_r;
  end

  // square root, two radicand bits per stage
  logic            sq_vld_r [RW];
  logic [REMW-1:0] sq_rem_r [RW];
  logic [RW-1:0]   sq_q_r   [RW];
  logic [XW-1:0]   sq_x_r   [RW];
  logic [OW-1:0]   sq_off_r [RW];

  for (genvar k = 0; k < RW; k++) begin : g_sq
    logic            vin;
    logic [REMW-1:0] rin;
    logic [RW-1:0]   qin;
    logic [XW-1:0]   xin;
    logic [OW-1:0]   oin;
    logic [REMW+1:0] rs, trial, diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign vin = b2_vld_r;
      assign rin = '0;
      assign qin = '0;
      assign xin = {d2_r, 12'b0};
      assign oin = b2_off_r;
    end else begin : g_next
      assign vin = sq_vld_r[k-1];
      assign rin = sq_rem_r[k-1];
      assign qin = sq_q_r[k-1];
      assign xin = sq_x_r[k-1];
      assign oin = sq_off_r[k-1];
    end

    assign rs    = {rin, xin[XW-1 -: 2]};
    assign trial = {2'b0, qin, 2'b01};
    assign ge    = rs >= trial;
    assign diff  = rs - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k] <= 1'b0;
      end else begin
        sq_vld_r[k] <= vin;
      end
      sq_rem_r[k] <= ge ? diff[REMW-1:0] : rs[REMW-1:0];
      sq_q_r[k]   <= {qin[RW-2:0], ge};
      sq_x_r[k]   <= {xin[XW-3:0], 2'b00};
      sq_off_r[k] <= oin;
    end
  end

  // scale to nanoseconds
  logic          m_vld_r;
  logic [D1-1:0] m_r;
  logic [OW-1:0] m_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= sq_vld_r[RW-1];
    end
    m_r     <= {10'b0, sq_q_r[RW-1]} * {31'b0, tofdi_pkg::NS_PER_US};
    m_off_r <= sq_off_r[RW-1];
  end

  logic          t_vld;
  logic [D1-1:0] t_q;
  logic [OW-1:0] t_off;

  tofdi_udiv #(.DW(D1), .VW(tofdi_pkg::SPEED_W), .PW(OW)) u_div_t (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (m_vld_r),
    .dvd_i (m_r),
    .div_i (c_eff),
    .pay_i (m_off_r),
    .vld_o (t_vld),
    .quo_o (t_q),
    .rem_o (),
    .pay_o (t_off)
  );

  // numerator, folded to a magnitude: ~n = -n-1 for negative n
  logic          n_vld_r;
  logic [D2-1:0] n_mag_r;
  logic          n_neg_r;
  logic [33:0]   offsd;
  logic [43:0]   n_sum;

  assign offsd = {t_off[OW-1], t_off} - {{2{cfg.start_delay[31]}}, cfg.start_delay};
  assign n_sum = {3'b0, t_q} + {{4{offsd[33]}}, offsd, 6'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_vld_r <= 1'b0;
    end else begin
      n_vld_r <= t_vld;
    end
    n_neg_r <= n_sum[43];
    n_mag_r <= n_sum[43] ? ~n_sum[D2-1:0] : n_sum[D2-1:0];
  end

  logic           s_vld, s_neg;
  logic [D2-1:0]  s_q;
  logic [VW2-1:0] s_rem;

  tofdi_udiv #(.DW(D2), .VW(VW2), .PW(1)) u_div_s (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (n_vld_r),
    .dvd_i (n_mag_r),
    .div_i (dsr),
    .pay_i (n_neg_r),
    .vld_o (s_vld),
    .quo_o (s_q),
    .rem_o (s_rem),
    .pay_o (s_neg)
  );

  // floor quotient and remainder, round half to even
  logic          r_vld_r;
  logic [QW-1:0] q_r;
  logic [QW-1:0] qf;
  logic [VW2-1:0] rf;
  logic          up;

  assign qf = s_neg ? ~{2'b0, s_q} : {2'b0, s_q};
  assign rf = s_neg ? (dsr - 1'b1 - s_rem) : s_rem;
  assign up = ({rf, 1'b0} > {1'b0, dsr}) || (({rf, 1'b0} == {1'b0, dsr}) && qf[0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_vld_r <= 1'b0;
    end else begin
      r_vld_r <= s_vld;
    end
    q_r <= qf + {{(QW-1){1'b0}}, up};
  end

  // window check and saturation
  logic        qneg, hi;
  logic [45:0] over;
  logic        fits;
  logic [31:0] over_sat;

  assign qneg = q_r[QW-1];
  assign hi   = !qneg && (q_r >= {11'b0, win});
  assign over = qneg ? {q_r[QW-1], q_r} : ({1'b0, q_r} - {12'b0, win} + 46'd1);
  assign fits = (&over[45:31]) || (~|over[45:31]);
  assign over_sat = fits ? over[31:0] : (over[45] ? 32'h8000_0000 : 32'h7FFF_FFFF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= r_vld_r;
    end
    out_out_of_range <= qneg || hi;
    out_sample_index <= (qneg || hi) ? '0 : q_r[INDEX_BITS-1:0];
    out_overshoot    <= (qneg || hi) ? $signed(over_sat) : '0;
  end

endmodule

>>> bench/time_of_flight_delay_index_test.sv
// ----------------------------------------------------------------------------
// time_of_flight_delay_index_test
// Self-checking bench: random and directed element/point words are pushed
// through the delay index block under several register settings and idle
// patterns; each strobed result is checked against an in-bench predictor.
// ----------------------------------------------------------------------------
module time_of_flight_delay_index_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDX_W     = 16;
  localparam int unsigned WATCHDOG  = 20000;

  typedef struct {
    logic signed [23:0] ox, oy, oz, ex, ey, ez;
    logic signed [31:0] foc, steer;
  } word_t;

  typedef struct {
    logic [IDX_W-1:0]   idx;
    logic               oor;
    logic signed [31:0] over;
  } delay_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [23:0] in_obs_x = '0, in_obs_y = '0, in_obs_z = '0;
  logic signed [23:0] in_elem_x = '0, in_elem_y = '0, in_elem_z = '0;
  logic signed [31:0] in_focus_offset = '0, in_steer_offset = '0;
  logic out_strobe;
  logic [IDX_W-1:0] out_sample_index;
  logic out_out_of_range;
  logic signed [31:0] out_overshoot;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [tofdi_pkg::ADDR_W-1:0] paddr = '0;
  logic [tofdi_pkg::DATA_W-1:0] pwdata = '0;
  logic [tofdi_pkg::DATA_W-1:0] prdata;
  logic pready;

  time_of_flight_delay_index #(.INDEX_BITS(IDX_W)) DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bench copy of the register file
  logic [tofdi_pkg::SPEED_W-1:0]  speed_r  = 15'd1500;
  logic [tofdi_pkg::PERIOD_W-1:0] period_r = 20'd100;
  logic [tofdi_pkg::DELAY_W-1:0]  sdelay_r = '0;
  logic [tofdi_pkg::NSAMP_W-1:0]  nsamp_r  = 17'd1024;

  word_t  pending_words[$];
  delay_t expected_delays[$];
  int     idle_pct = 0;
  int     mismatches = 0;
  int     words_taken = 0, delays_seen = 0, oor_seen = 0;
  int     quiet_cycles = 0;

  // integer square root by the usual bit-pair method
  function automatic longint unsigned root_of(longint unsigned x);
    longint unsigned res, bitv;
    res  = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x  -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic delay_t delay_of(word_t w);
    delay_t r;
    longint dx, dy, dz, t, n, d, q, rm, over, win, cap;
    longint unsigned d2, rt, c, p;
    dx = longint'(w.ox) - longint'(w.ex);
    dy = longint'(w.oy) - longint'(w.ey);
    dz = longint'(w.oz) - longint'(w.ez);
    d2 = unsigned'(dx*dx + dy*dy + dz*dz);
    rt = root_of(d2 << 12);
    c  = (speed_r == '0) ? 64'd1 : 64'(speed_r);
    p  = (period_r == '0) ? 64'd1 : 64'(period_r);
    t  = longint'((rt * 64'd1000) / c);
    n  = t + 64 * (longint'(w.foc) + longint'(w.steer) - longint'($signed(sdelay_r)));
    d  = longint'(p * 64'd64);
    q  = n / d;
    rm = n % d;
    if (rm < 0) begin
      q  -= 1;
      rm += d;
    end
    // round to nearest, ties to even
    if (2*rm > d || (2*rm == d && q[0])) q += 1;
    cap = 64'sd1 <<< IDX_W;
    win = (longint'(nsamp_r) > cap) ? cap : longint'(nsamp_r);
    r.idx = '0;
    r.oor = 1'b0;
    over  = 0;
    if (q < 0) begin
      r.oor = 1'b1;
      over  = q;
    end else if (q >= win) begin
      r.oor = 1'b1;
      over  = q - win + 1;
    end else begin
      r.idx = q[IDX_W-1:0];
    end
    if (over > 64'sd2147483647) over = 64'sd2147483647;
    if (over < -64'sd2147483648) over = -64'sd2147483648;
    r.over = over[31:0];
    return r;
  endfunction

  function automatic word_t random_word(bit near);
    word_t w;
    if (near) begin
      // points within a few cm keep indices inside a typical window
      w.ex = 24'(int'($urandom_range(0, 80000)) - 40000);
      w.ey = 24'(int'($urandom_range(0, 80000)) - 40000);
      w.ez = 24'(int'($urandom_range(0, 20000)) - 10000);
      w.ox = 24'(int'($urandom_range(0, 80000)) - 40000);
      w.oy = 24'(int'($urandom_range(0, 80000)) - 40000);
      w.oz = 24'($urandom_range(0, 80000));
      w.foc   = int'($urandom_range(0, 4000)) - 2000;
      w.steer = int'($urandom_range(0, 4000)) - 2000;
    end else begin
      w.ox = 24'($urandom); w.oy = 24'($urandom); w.oz = 24'($urandom);
      w.ex = 24'($urandom); w.ey = 24'($urandom); w.ez = 24'($urandom);
      w.foc = $urandom; w.steer = $urandom;
    end
    return w;
  endfunction

  // driver: one word per accepted start, random idling
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        words_taken <= words_taken + 1;
        expected_delays.push_back(delay_of(pending_words.pop_front()));
      end
      if (pending_words.size() > 0 &&
          $urandom_range(0, 99) >= idle_pct) begin
        // front of the queue is the word on the ports or the next in line
        word_t w;
        w = pending_words[0];
        in_obs_x <= w.ox; in_obs_y <= w.oy; in_obs_z <= w.oz;
        in_elem_x <= w.ex; in_elem_y <= w.ey; in_elem_z <= w.ez;
        in_focus_offset <= w.foc; in_steer_offset <= w.steer;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every strobe must match the oldest expected delay
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      delay_t e;
      delays_seen <= delays_seen + 1;
      if (expected_delays.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result word at %0t", $realtime);
      end else begin
        e = expected_delays.pop_front();
        if (out_out_of_range) oor_seen <= oor_seen + 1;
        if (e.idx !== out_sample_index || e.oor !== out_out_of_range ||
            e.over !== out_overshoot) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: exp idx %0d oor %0b over %0d, got idx %0d oor %0b over %0d",
                     e.idx, e.oor, e.over, out_sample_index, out_out_of_range,
                     out_overshoot);
        end
      end
    end
  end

  // watchdog on cycles with no traffic
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("** time_of_flight_delay_index: FAILED **");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= tofdi_pkg::ADDR_W'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      tofdi_pkg::REG_SOUND_SPEED:   speed_r  = val[tofdi_pkg::SPEED_W-1:0];
      tofdi_pkg::REG_SAMPLE_PERIOD: period_r = val[tofdi_pkg::PERIOD_W-1:0];
      tofdi_pkg::REG_START_DELAY:   sdelay_r = val;
      tofdi_pkg::REG_NUM_SAMPLES:   nsamp_r  = val[tofdi_pkg::NSAMP_W-1:0];
      default: ;
    endcase
  endtask

  // wait for all queued words to go in and all results to come back
  task automatic drain();
    while (pending_words.size() > 0 || start || expected_delays.size() > 0)
      @(posedge clk);
    repeat (tofdi_pkg::LATENCY + 4) @(posedge clk);
  endtask

  task automatic phase(int n, int pct, int near_pct);
    idle_pct = pct;
    repeat (n) pending_words.push_back(random_word($urandom_range(0, 99) < near_pct));
    drain();
  endtask

  initial begin
    word_t w;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, zero distance, ties, window edges
    w = '{default: '0};
    pending_words.push_back(w);                       // zero distance, index 0
    w.ox = 24'sh7FFFFF; w.oy = 24'sh7FFFFF; w.oz = 24'sh7FFFFF;
    w.ex = -24'sh800000; w.ey = -24'sh800000; w.ez = -24'sh800000;
    pending_words.push_back(w);                       // longest distance
    w = '{default: '0};
    w.foc = 32'sh7FFFFFFF; w.steer = 32'sh7FFFFFFF;
    pending_words.push_back(w);                       // huge overshoot
    w.foc = 32'sh80000000; w.steer = 32'sh80000000;
    pending_words.push_back(w);                       // very negative
    w.steer = 0;
    for (int k = 0; k < 6; k++) begin
      w.foc = 50 + 100*k;                             // exact half-sample ties
      pending_words.push_back(w);
    end
    w.foc = 102350; pending_words.push_back(w);       // tie at the upper edge of the default window
    w.foc = 102349; pending_words.push_back(w);
    w.foc = -51;    pending_words.push_back(w);       // just below zero
    w.foc = -50;    pending_words.push_back(w);
    idle_pct = 0;
    drain();

    // extremes of the registers, including the zero special cases
    reg_write(tofdi_pkg::REG_SOUND_SPEED, 0);
    reg_write(tofdi_pkg::REG_SAMPLE_PERIOD, 0);
    reg_write(tofdi_pkg::REG_START_DELAY, 32'h8000_0000);
    reg_write(tofdi_pkg::REG_NUM_SAMPLES, 0);
    phase(20, 0, 50);
    reg_write(tofdi_pkg::REG_SOUND_SPEED, 32'h7FFF);
    reg_write(tofdi_pkg::REG_SAMPLE_PERIOD, 32'hFFFFF);
    reg_write(tofdi_pkg::REG_START_DELAY, 32'h7FFF_FFFF);
    reg_write(tofdi_pkg::REG_NUM_SAMPLES, 32'h1FFFF);
    phase(20, 56, 50);

    // sane settings for the bulk of the run, several idle patterns
    reg_write(tofdi_pkg::REG_SOUND_SPEED, 1500);
    reg_write(tofdi_pkg::REG_SAMPLE_PERIOD, 50);
    reg_write(tofdi_pkg::REG_START_DELAY, 0);
    reg_write(tofdi_pkg::REG_NUM_SAMPLES, 65536);
    phase(136, 0, 85);
    phase(90, 56, 85);
    reg_write(tofdi_pkg::REG_SOUND_SPEED, $urandom_range(100, 20000));
    reg_write(tofdi_pkg::REG_SAMPLE_PERIOD, $urandom_range(1, 400));
    reg_write(tofdi_pkg::REG_START_DELAY, $urandom_range(0, 20000) - 10000);
    reg_write(tofdi_pkg::REG_NUM_SAMPLES, $urandom_range(1, 4096));
    phase(90, 13, 80);
    reg_write(tofdi_pkg::REG_SAMPLE_PERIOD, 1);
    reg_write(tofdi_pkg::REG_NUM_SAMPLES, 1);
    phase(80, 56, 80);

    $display("%0d words taken, %0d results checked (%0d out of window)",
             words_taken, delays_seen, oor_seen);
    $display("registers swept through zero, reset-like and maximum settings");
    if (mismatches == 0) begin
      $display("** time_of_flight_delay_index: PASSED **");
    end else begin
      $display("** time_of_flight_delay_index: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/tofdi_pkg.sv
hdl/tofdi_front.sv
hdl/tofdi_fifo.sv
hdl/tofdi_udiv.sv
hdl/tofdi_back.sv
hdl/time_of_flight_delay_index.sv
bench/time_of_flight_delay_index_test.sv
